[hdl/gml_pkg.sv]
`timescale 1ns / 1ps
// Measurement latch package: shared types, register map and constants.
// No dependencies.
package gml_pkg;

	localparam int CHANNELS_DEF = 12;
	localparam int QUEUE_DEPTH  = 2;
	localparam int CHAN_W       = 4;
	localparam int MASK_W       = 12;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	localparam logic [10:0] MAX_PHASE_RST = 11'd2046;
	localparam logic [4:0]  EPOCH1_MASK   = 5'h1f;
	localparam logic [4:0]  EPOCH1_WRAP   = 5'd19;
	localparam logic [8:0]  EPOCH20_MAX   = 9'd49;

	typedef enum logic [1:0] {
		REG_SIG_THRESH = 2'd0,
		REG_MIN_CLK    = 2'd1,
		REG_MAX_PHASE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] sig_thresh;
		logic [2:0]  min_clk;
		logic [10:0] max_phase;
	} cfg_t;

	// one classified reading, front to back
	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic              in_range;
		logic              valid;
		logic [10:0]       phase;
		logic [5:0]        e1;
		logic [7:0]        e20;
		logic [31:0]       carr;
		logic [15:0]       cdco;
		logic [15:0]       codedco;
		logic              missed;
		logic              last;
	} entry_t;

endpackage

[hdl/gml_front.sv]
`timescale 1ns / 1ps
// Front end: accepts readings, qualifies them and applies the code phase
// overflow correction. Depends on gml_pkg.
module gml_front import gml_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAN_W-1:0] channel,
	input  logic              locked,
	input  logic [15:0]       signal_avg,
	input  logic [2:0]        clock_state,
	input  logic              time_set,
	input  logic [10:0]       chip_phase_in,
	input  logic [31:0]       carr_cycles_in,
	input  logic [15:0]       carrier_dco_phase_in,
	input  logic [15:0]       epoch_word,
	input  logic [15:0]       code_dco_phase_in,
	input  logic              missed_flag,
	input  logic              last_channel,
	input  logic              q_full,
	output logic              q_push,
	output entry_t            q_data
);

	localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W+1)'(CHANNELS);

	logic   valid_s1;
	entry_t entry_s1;
	entry_t entry_d;
	logic   load;
	logic   in_range;
	logic   qual;
	logic   [7:0] raw20;
	logic   [4:0] raw1;
	logic   [8:0] e20_inc;

	assign in_range = {1'b0, channel} < CHAN_LIMIT;
	assign qual = in_range && locked && (signal_avg > cfg.sig_thresh) &&
		(clock_state >= cfg.min_clk) && time_set;
	assign raw20 = epoch_word[15:8];
	assign raw1 = epoch_word[4:0] & EPOCH1_MASK;
	assign e20_inc = {1'b0, raw20} + 9'd1;

	always_comb begin
		entry_d          = '0;
		entry_d.channel  = channel;
		entry_d.in_range = in_range;
		entry_d.valid    = qual;
		entry_d.missed   = missed_flag;
		entry_d.last     = last_channel;
		if (qual) begin
			entry_d.carr    = carr_cycles_in;
			entry_d.cdco    = carrier_dco_phase_in;
			entry_d.codedco = code_dco_phase_in;
			if (chip_phase_in < cfg.max_phase) begin
				entry_d.phase = chip_phase_in;
				entry_d.e1    = {1'b0, raw1};
				entry_d.e20   = raw20;
			end else begin
				entry_d.phase = chip_phase_in - cfg.max_phase;
				if (raw1 == EPOCH1_WRAP) begin
					entry_d.e1  = '0;
					entry_d.e20 = (e20_inc > EPOCH20_MAX) ? 8'd0 : e20_inc[7:0];
				end else begin
					entry_d.e1  = {1'b0, raw1} + 6'd1;
					entry_d.e20 = raw20;
				end
			end
		end
	end

	assign q_push   = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign load     = in_valid && !in_stall;
	assign q_data   = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

[hdl/gml_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified readings between front and back end.
// Depends on gml_pkg.
module gml_queue import gml_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	input  logic   pop,
	output entry_t rdata,
	output logic   full,
	output logic   empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rdata = slots_q[rptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= wdata;
		end
	end

endmodule

[hdl/gml_back.sv]
`timescale 1ns / 1ps
// Back end: missed TIC counters, ready mask, clear decision and the result
// register. Depends on gml_pkg.
module gml_back import gml_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  entry_t            q_data,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAN_W-1:0] out_channel,
	output logic              valid_res,
	output logic [10:0]       corrected_phase,
	output logic [5:0]        ms_epoch,
	output logic [7:0]        bit_epoch,
	output logic [31:0]       carr_cycles_out,
	output logic [15:0]       carrier_dco_phase_out,
	output logic [15:0]       code_dco_phase_out,
	output logic [15:0]       missed_total,
	output logic [MASK_W-1:0] ready_mask,
	output logic              clear_ranges,
	output logic              last
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [15:0]         missed_q [CHANNELS];
	logic [CHANNELS-1:0] accum_q;
	logic                prev_any_q;
	logic                out_valid_q;
	entry_t              res_q;
	logic [15:0]         total_q;
	logic [MASK_W-1:0]   mask_q;
	logic                clear_q;

	logic [IDX_W-1:0]    idx;
	logic [15:0]         cnt_next;
	logic [CHANNELS-1:0] hit;
	logic [CHANNELS-1:0] mask_now;
	logic [MASK_W-1:0]   mask_out;
	logic                clear_now;

	assign q_pop = !q_empty && (!out_valid_q || !out_stall);
	assign idx = q_data.channel[IDX_W-1:0];
	assign cnt_next = missed_q[idx] + {15'd0, q_data.missed};

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			hit[i] = q_data.valid && (q_data.channel == CHAN_W'(i));
		end
	end

	assign mask_now  = accum_q | hit;
	assign clear_now = q_data.last && (mask_now == '0) && prev_any_q;

	// mask bits above the result field width still count for the clear decision
	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < CHANNELS) begin : g_on
			assign mask_out[g] = mask_now[g];
		end else begin : g_off
			assign mask_out[g] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				missed_q[i] <= '0;
			end
			accum_q     <= '0;
			prev_any_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				if (q_data.in_range) begin
					missed_q[idx] <= cnt_next;
				end
				if (q_data.last) begin
					accum_q    <= '0;
					prev_any_q <= |mask_now;
				end else begin
					accum_q <= mask_now;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q   <= q_data;
			total_q <= q_data.in_range ? cnt_next : 16'd0;
			mask_q  <= mask_out;
			clear_q <= clear_now;
		end
	end

	assign out_valid             = out_valid_q;
	assign out_channel           = res_q.channel;
	assign valid_res             = res_q.valid;
	assign corrected_phase       = res_q.phase;
	assign ms_epoch              = res_q.e1;
	assign bit_epoch             = res_q.e20;
	assign carr_cycles_out       = res_q.carr;
	assign carrier_dco_phase_out = res_q.cdco;
	assign code_dco_phase_out    = res_q.codedco;
	assign missed_total          = total_q;
	assign ready_mask            = mask_q;
	assign clear_ranges          = clear_q;
	assign last                  = res_q.last;

endmodule

[hdl/gps_measurement_latch.sv]
`timescale 1ns / 1ps
// Measurement latch top level: configuration registers, front end, queue
// and back end. Depends on gml_pkg, gml_front, gml_queue and gml_back.
//
// Takes one correlator channel reading per beat and returns one measurement
// per reading, in order. Throughput is one reading per clock unless in_stall
// or out_stall holds the flow; a reading's measurement passes through the
// input register, a queue slot and the result register. The two-entry queue
// lets the input side keep taking beats for a short while when the output is
// stalled. Configuration is written over the APB port at byte addresses 0
// (signal loss threshold), 4 (minimum clock state) and 8 (maximum code phase);
// the user must write it only while the block is idle; the block does not enforce this.
module gps_measurement_latch import gml_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CHAN_W-1:0]  channel,
	input  logic               locked,
	input  logic [15:0]        signal_avg,
	input  logic [2:0]         clock_state,
	input  logic               time_set,
	input  logic [10:0]        chip_phase_in,
	input  logic [31:0]        carr_cycles_in,
	input  logic [15:0]        carrier_dco_phase_in,
	input  logic [15:0]        epoch_word,
	input  logic [15:0]        code_dco_phase_in,
	input  logic               missed_flag,
	input  logic               last_channel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CHAN_W-1:0]  out_channel,
	output logic               valid_res,
	output logic [10:0]        corrected_phase,
	output logic [5:0]         ms_epoch,
	output logic [7:0]         bit_epoch,
	output logic [31:0]        carr_cycles_out,
	output logic [15:0]        carrier_dco_phase_out,
	output logic [15:0]        code_dco_phase_out,
	output logic [15:0]        missed_total,
	output logic [MASK_W-1:0]  ready_mask,
	output logic               clear_ranges,
	output logic               last
);

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	entry_t   q_wdata;
	entry_t   q_rdata;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sig_thresh <= '0;
			cfg_q.min_clk    <= '0;
			cfg_q.max_phase  <= MAX_PHASE_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SIG_THRESH: cfg_q.sig_thresh <= pwdata[15:0];
				REG_MIN_CLK:    cfg_q.min_clk    <= pwdata[2:0];
				REG_MAX_PHASE:  cfg_q.max_phase  <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SIG_THRESH: prdata = {16'd0, cfg_q.sig_thresh};
			REG_MIN_CLK:    prdata = {29'd0, cfg_q.min_clk};
			REG_MAX_PHASE:  prdata = {21'd0, cfg_q.max_phase};
			default:        prdata = '0;
		endcase
	end

	gml_front #(.CHANNELS(CHANNELS)) u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg_q),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.channel              (channel),
		.locked               (locked),
		.signal_avg           (signal_avg),
		.clock_state          (clock_state),
		.time_set             (time_set),
		.chip_phase_in        (chip_phase_in),
		.carr_cycles_in       (carr_cycles_in),
		.carrier_dco_phase_in (carrier_dco_phase_in),
		.epoch_word           (epoch_word),
		.code_dco_phase_in    (code_dco_phase_in),
		.missed_flag          (missed_flag),
		.last_channel         (last_channel),
		.q_full               (q_full),
		.q_push               (q_push),
		.q_data               (q_wdata)
	);

	gml_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	gml_back #(.CHANNELS(CHANNELS)) u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.q_data                (q_rdata),
		.q_empty               (q_empty),
		.q_pop                 (q_pop),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.out_channel           (out_channel),
		.valid_res             (valid_res),
		.corrected_phase       (corrected_phase),
		.ms_epoch              (ms_epoch),
		.bit_epoch             (bit_epoch),
		.carr_cycles_out       (carr_cycles_out),
		.carrier_dco_phase_out (carrier_dco_phase_out),
		.code_dco_phase_out    (code_dco_phase_out),
		.missed_total          (missed_total),
		.ready_mask            (ready_mask),
		.clear_ranges          (clear_ranges),
		.last                  (last)
	);

endmodule
